// ----- src/mwm_pkg.sv -----
// mwm_pkg: shared types and constants for the mecanum wheel mixer
// depends on nothing
`default_nettype none
package mwm_pkg;
    localparam int QW       = 15;
    localparam int NW       = 26;
    localparam int DW       = 11;
    localparam int LANES    = 4;
    localparam int GSHIFT   = 14;
    localparam int CFG_AW   = 8;

    localparam logic [CFG_AW-1:0] REG_GAIN_LF = 8'd0;
    localparam logic [CFG_AW-1:0] REG_GAIN_RB = 8'd1;
    localparam logic [CFG_AW-1:0] REG_GAIN_LB = 8'd2;
    localparam logic [CFG_AW-1:0] REG_GAIN_RF = 8'd3;

    localparam logic signed [15:0] GAIN_ONE = 16'sd16384;
    localparam logic signed [15:0] QMAX     = 16'sd32767;

    typedef logic signed [15:0] t_s16;
    typedef t_s16 [LANES-1:0] t_gains;

    typedef struct packed {
        logic [7:0] strafe_byte;
        logic [7:0] forward_byte;
        logic [7:0] rotate_byte;
    } t_cmd;

    typedef struct packed {
        logic signed [15:0] left_front_cmd;
        logic signed [15:0] right_back_cmd;
        logic signed [15:0] left_back_cmd;
        logic signed [15:0] right_front_cmd;
    } t_res;

    typedef struct packed {
        logic          neg;
        logic [NW-1:0] rem;
        logic [QW-1:0] quo;
    } t_lane;

    typedef t_lane [LANES-1:0] t_lanes;
endpackage
`default_nettype wire

// ----- src/mecanum_wheel_mixer.sv -----
// mecanum_wheel_mixer: pipelined mixer, results on o_done, one command per cycle
// latency set by 2 front, 15 quotient and 3 gain stages, o_busy is always low
// synchronous active-low reset clears valid bits and sets all gains to 1.0
// results are strobed for one cycle; the receiver cannot stall
// depends on mwm_pkg, mwm_front, mwm_div, mwm_gain
`default_nettype none
module mecanum_wheel_mixer import mwm_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire t_cmd              i_cmd,
    output logic                   o_done,
    output t_res                   o_res,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CFG_AW-1:0] i_cfg_index,
    input  wire logic [15:0]       i_cfg_data
);
    t_gains        r_gains;
    logic          f_valid, d_valid;
    t_lanes        f_lanes, d_lanes;
    logic [DW-1:0] f_den;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains <= {LANES{GAIN_ONE}};
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_GAIN_LF: r_gains[0] <= i_cfg_data;
                REG_GAIN_RB: r_gains[1] <= i_cfg_data;
                REG_GAIN_LB: r_gains[2] <= i_cfg_data;
                REG_GAIN_RF: r_gains[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mwm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start && !o_busy),
        .i_cmd   (i_cmd),
        .o_valid (f_valid),
        .o_lanes (f_lanes),
        .o_den   (f_den)
    );

    mwm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_lanes (f_lanes),
        .i_den   (f_den),
        .o_valid (d_valid),
        .o_lanes (d_lanes)
    );

    mwm_gain u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d_valid),
        .i_lanes (d_lanes),
        .i_gains (r_gains),
        .o_valid (o_done),
        .o_res   (o_res)
    );

    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, 20))
        else $error("result without a command");

    a_no_min_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_res.left_front_cmd != -16'sd32768 &&
                    o_res.right_back_cmd != -16'sd32768))
        else $error("saturation failed");

    a_no_min_lb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_res.left_back_cmd != -16'sd32768 &&
                    o_res.right_front_cmd != -16'sd32768))
        else $error("saturation failed");
endmodule
`default_nettype wire

// ----- src/mwm_front.sv -----
// mwm_front: maps bytes to axes, forms wheel sums and divider operands
// depends on mwm_pkg
`default_nettype none
module mwm_front import mwm_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire t_cmd          i_cmd,
    output logic               o_valid,
    output t_lanes             o_lanes,
    output logic [DW-1:0]      o_den
);
    logic signed [9:0]  x, y, r;
    logic [9:0]         ax, ay, ar;
    logic signed [10:0] n_sum [LANES];
    logic [9:0]         n_d;

    logic               r_v1;
    logic signed [10:0] r_sum [LANES];
    logic [9:0]         r_d;

    logic               r_v2;
    t_lanes             r_lanes;
    logic [DW-1:0]      r_den;

    always_comb begin
        x  = $signed({1'b0, i_cmd.strafe_byte, 1'b0}) - 10'sd255;
        y  = 10'sd255 - $signed({1'b0, i_cmd.forward_byte, 1'b0});
        r  = 10'sd255 - $signed({1'b0, i_cmd.rotate_byte, 1'b0});
        ax = x[9] ? 10'(-x) : 10'(x);
        ay = y[9] ? 10'(-y) : 10'(y);
        ar = r[9] ? 10'(-r) : 10'(r);
        n_d = ax + ay + ar;
        n_sum[0] = 11'(x) + 11'(y) - 11'(r);
        n_sum[1] = 11'(x) + 11'(y) + 11'(r);
        n_sum[2] = -11'(x) + 11'(y) - 11'(r);
        n_sum[3] = -11'(x) + 11'(y) + 11'(r);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_sum <= n_sum;
        r_d   <= n_d;
    end

    logic [9:0]    mag [LANES];
    logic [9:0]    dcl;
    t_lanes        n_lanes;

    always_comb begin
        dcl = (r_d < 10'd255) ? 10'd255 : r_d;
        for (int i = 0; i < LANES; i++) begin
            mag[i] = r_sum[i][10] ? 10'(-r_sum[i]) : 10'(r_sum[i]);
            n_lanes[i].neg = r_sum[i][10];
            n_lanes[i].rem = ({16'd0, mag[i]} << 16) - ({16'd0, mag[i]} << 1)
                             + {16'd0, dcl};
            n_lanes[i].quo = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lanes <= n_lanes;
        r_den   <= {dcl, 1'b0};
    end

    assign o_valid = r_v2;
    assign o_lanes = r_lanes;
    assign o_den   = r_den;
endmodule
`default_nettype wire

// ----- src/mwm_div.sv -----
// mwm_div: pipelined restoring divider, one quotient bit per stage, four lanes
// depends on mwm_pkg
`default_nettype none
module mwm_div import mwm_pkg::*; (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire t_lanes        i_lanes,
    input  wire logic [DW-1:0] i_den,
    output logic               o_valid,
    output t_lanes             o_lanes
);
    logic          r_v    [QW+1];
    logic [DW-1:0] r_den  [QW+1];
    t_lanes        r_lane [QW+1];

    assign r_v[0]    = i_valid;
    assign r_den[0]  = i_den;
    assign r_lane[0] = i_lanes;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int B = QW - 1 - k;
        logic [NW-1:0] dsh;
        t_lanes        n_lane;
        always_comb begin
            dsh = NW'(r_den[k]) << B;
            n_lane = r_lane[k];
            for (int i = 0; i < LANES; i++) begin
                if (r_lane[k][i].rem >= dsh) begin
                    n_lane[i].rem    = r_lane[k][i].rem - dsh;
                    n_lane[i].quo[B] = 1'b1;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
            r_den[k+1]  <= r_den[k];
            r_lane[k+1] <= n_lane;
        end
    end

    assign o_valid = r_v[QW];
    assign o_lanes = r_lane[QW];
endmodule
`default_nettype wire

// ----- src/mwm_gain.sv -----
// mwm_gain: signs quotients, applies calibration gains, saturates
// depends on mwm_pkg
`default_nettype none
module mwm_gain import mwm_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  wire t_lanes i_lanes,
    input  wire t_gains i_gains,
    output logic        o_valid,
    output t_res        o_res
);
    logic               r_va, r_vb, r_vc;
    logic signed [15:0] r_q [LANES];
    logic signed [31:0] r_p [LANES];
    t_s16               n_out [LANES];
    t_res               r_res;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            logic signed [17:0] s;
            s = 18'(r_p[i] >>> GSHIFT);
            if (s > 18'sd32767) begin
                n_out[i] = QMAX;
            end else if (s < -18'sd32767) begin
                n_out[i] = -QMAX;
            end else begin
                n_out[i] = s[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
        for (int i = 0; i < LANES; i++) begin
            r_q[i] <= i_lanes[i].neg ? -$signed({1'b0, i_lanes[i].quo})
                                     :  $signed({1'b0, i_lanes[i].quo});
            r_p[i] <= 32'(r_q[i]) * 32'(i_gains[i]);
        end
        r_res.left_front_cmd  <= n_out[0];
        r_res.right_back_cmd  <= n_out[1];
        r_res.left_back_cmd   <= n_out[2];
        r_res.right_front_cmd <= n_out[3];
    end

    assign o_valid = r_vc;
    assign o_res   = r_res;
endmodule
`default_nettype wire
